// ----- rtl/mm3_pkg.sv -----
// Shared types, constants and rotate helpers for the MurmurHash3 x86_32 core.
`timescale 1ns / 1ps
package mm3_pkg;

   localparam logic [31:0] MM_C1 = 32'hcc9e2d51;
   localparam logic [31:0] MM_C2 = 32'h1b873593;
   localparam logic [31:0] MM_N  = 32'he6546b64;
   localparam logic [31:0] MM_F1 = 32'h85ebca6b;
   localparam logic [31:0] MM_F2 = 32'hc2b2ae35;

   localparam logic [2:0] BLOCK_BYTES = 3'd4;

   typedef struct packed {
      logic [31:0] word;
      logic [2:0]  nbytes;
      logic        full;
      logic        last;
   } entry_type;

   function automatic logic [31:0] rotl15(input logic [31:0] x);
      return {x[16:0], x[31:17]};
   endfunction

   function automatic logic [31:0] rotl13(input logic [31:0] x);
      return {x[18:0], x[31:19]};
   endfunction

endpackage

// ----- rtl/mm3_front.sv -----
// Request front end: force non-last words full, saturate the byte count, mask the tail and classify the word.
`timescale 1ns / 1ps
module mm3_front (
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [31:0]       req_data_word,
   input  logic [2:0]        req_byte_count,
   input  logic              req_last,
   output logic              push_valid,
   input  logic              push_ready,
   output mm3_pkg::entry_type push_entry
);
   import mm3_pkg::*;

   logic [2:0]  count;
   logic [31:0] mask;

   always_comb begin
      if (!req_last || req_byte_count > BLOCK_BYTES) begin
         count = BLOCK_BYTES;
      end else begin
         count = req_byte_count;
      end
      case (count)
         3'd0:    mask = 32'h00000000;
         3'd1:    mask = 32'h000000ff;
         3'd2:    mask = 32'h0000ffff;
         3'd3:    mask = 32'h00ffffff;
         default: mask = 32'hffffffff;
      endcase
   end

   assign push_entry.word   = req_data_word & mask;
   assign push_entry.nbytes = count;
   assign push_entry.full   = (count == BLOCK_BYTES);
   assign push_entry.last   = req_last;
   assign push_valid        = req_valid;
   assign req_ready         = push_ready;

endmodule

// ----- rtl/mm3_queue.sv -----
// Small FIFO of classified requests between the front end and the hash engine.
`timescale 1ns / 1ps
module mm3_queue #(
   parameter int DEPTH = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  mm3_pkg::entry_type push_entry,
   output logic               pop_valid,
   input  logic               pop,
   output mm3_pkg::entry_type pop_entry
);
   import mm3_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   entry_type         slot_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign push_ready = (count_ff != FULL_CNT);
   assign pop_valid  = (count_ff != '0);
   assign pop_entry  = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ----- rtl/mm3_back.sv -----
// Hash engine: block scramble, running-hash mix and final avalanche on one shared multiplier.
`timescale 1ns / 1ps
module mm3_back (
   input  logic               clock,
   input  logic               reset,
   input  logic [31:0]        seed,
   input  logic               pop_valid,
   output logic               pop,
   input  mm3_pkg::entry_type pop_entry,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [31:0]        rsp_hash_value
);
   import mm3_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCR,
      S_MIX,
      S_FIN0,
      S_FIN1,
      S_FIN2
   } state_type;

   state_type   state_ff, state_in;
   entry_type   ent_ff, ent_in;
   logic [31:0] k_ff, k_in;
   logic [31:0] h_ff, h_in;
   logic [31:0] total_ff, total_in;
   logic        in_key_ff, in_key_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] hash_ff, hash_in;

   logic [31:0] mul_a, mul_b;
   logic [31:0] prod;
   logic [31:0] h_base, hx, hr, f0;

   assign prod   = mul_a * mul_b;
   assign h_base = in_key_ff ? h_ff : seed;
   assign hx     = h_base ^ k_ff;
   assign hr     = rotl13(hx);
   assign f0     = h_ff ^ total_ff;

   always_comb begin
      case (state_ff)
         S_SCR: begin
            mul_a = rotl15(k_ff);
            mul_b = MM_C2;
         end
         S_FIN0: begin
            mul_a = f0 ^ (f0 >> 16);
            mul_b = MM_F1;
         end
         S_FIN1: begin
            mul_a = k_ff ^ (k_ff >> 13);
            mul_b = MM_F2;
         end
         default: begin
            mul_a = pop_entry.word;
            mul_b = MM_C1;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      ent_in       = ent_ff;
      k_in         = k_ff;
      h_in         = h_ff;
      total_in     = total_ff;
      in_key_in    = in_key_ff;
      hash_in      = hash_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      pop          = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (pop_valid) begin
               pop      = 1'b1;
               ent_in   = pop_entry;
               k_in     = prod;
               state_in = S_SCR;
            end
         end
         S_SCR: begin
            k_in     = prod;
            state_in = S_MIX;
         end
         S_MIX: begin
            h_in     = ent_ff.full ? ({hr[29:0], 2'b00} + hr + MM_N) : hx;
            total_in = total_ff + {29'd0, ent_ff.nbytes};
            if (ent_ff.last) begin
               state_in = S_FIN0;
            end else begin
               in_key_in = 1'b1;
               state_in  = S_IDLE;
            end
         end
         S_FIN0: begin
            k_in     = prod;
            state_in = S_FIN1;
         end
         S_FIN1: begin
            k_in     = prod;
            state_in = S_FIN2;
         end
         S_FIN2: begin
            if (!rsp_valid_ff || rsp_ready) begin
               hash_in      = k_ff ^ (k_ff >> 16);
               rsp_valid_in = 1'b1;
               in_key_in    = 1'b0;
               total_in     = '0;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         total_ff     <= '0;
         in_key_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         in_key_ff    <= in_key_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ent_ff  <= ent_in;
      k_ff    <= k_in;
      h_ff    <= h_in;
      hash_ff <= hash_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hash_value = hash_ff;

endmodule

// ----- rtl/murmur3_32_stream_hash_core.sv -----
// A request is stored in the queue on acceptance; the engine pops it once it is idle.
// Each word passes the idle state (first product), then S_SCR and S_MIX; the last word then
// goes through S_FIN0, S_FIN1 and S_FIN2, and the hash is registered on rsp_ once rsp_ is free.
// The engine holds one word at a time on the single shared multiplier (two products per
// block, two for the avalanche). Reset (synchronous, active high) empties the queue,
// drops any key in progress and clears the seed to zero.
`timescale 1ns / 1ps
module murmur3_32_stream_hash_core #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_seed,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_data_word,
   input  logic [2:0]  req_byte_count,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_hash_value
);
   import mm3_pkg::*;

   logic [31:0] seed_ff;
   logic        push_valid, push_ready;
   entry_type   push_entry, pop_entry;
   logic        pop_valid, pop;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= '0;
      end else if (csr_valid) begin
         seed_ff <= csr_seed;
      end
   end

   mm3_front u_front (
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data_word  (req_data_word),
      .req_byte_count (req_byte_count),
      .req_last       (req_last),
      .push_valid     (push_valid),
      .push_ready     (push_ready),
      .push_entry     (push_entry)
   );

   mm3_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop        (pop),
      .pop_entry  (pop_entry)
   );

   mm3_back u_back (
      .clock          (clock),
      .reset          (reset),
      .seed           (seed_ff),
      .pop_valid      (pop_valid),
      .pop            (pop),
      .pop_entry      (pop_entry),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_hash_value (rsp_hash_value)
   );

endmodule

// ----- test/murmur3_hash_checker.sv -----
// Passive checker: predicts MurmurHash3 x86_32 results from observed requests and compares them.
`timescale 1ns / 1ps
module murmur3_hash_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [31:0] csr_seed,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [31:0] req_data_word,
   input  logic [2:0]  req_byte_count,
   input  logic        req_last,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [31:0] rsp_hash_value,
   output int          fail_count,
   output int          pending_count,
   output int          keys_hashed,
   output int          words_seen
);

   logic [31:0] seed_copy;
   logic [31:0] block_hash;
   logic [31:0] key_bytes;
   logic        key_open;
   logic [31:0] expected_hashes[$];
   int          mismatches;
   int          hashes_seen;
   int          requests_seen;

   initial begin
      fail_count    = 0;
      pending_count = 0;
      keys_hashed   = 0;
      words_seen    = 0;
      mismatches    = 0;
      hashes_seen   = 0;
      requests_seen = 0;
      seed_copy     = '0;
      block_hash    = '0;
      key_bytes     = '0;
      key_open      = 1'b0;
   end

   function automatic logic [31:0] rol32(input logic [31:0] x, input int unsigned r);
      return (x << r) | (x >> (32 - r));
   endfunction

   function automatic logic [31:0] scramble_block(input logic [31:0] k);
      logic [31:0] t;
      t = k * mm3_pkg::MM_C1;
      t = rol32(t, 15);
      return t * mm3_pkg::MM_C2;
   endfunction

   function automatic logic [31:0] mix_into(input logic [31:0] h, input logic [31:0] k);
      logic [31:0] t;
      t = rol32(h ^ scramble_block(k), 13);
      return t * 32'd5 + mm3_pkg::MM_N;
   endfunction

   function automatic logic [31:0] avalanche(input logic [31:0] h);
      logic [31:0] t;
      t = h ^ (h >> 16);
      t = t * mm3_pkg::MM_F1;
      t = t ^ (t >> 13);
      t = t * mm3_pkg::MM_F2;
      return t ^ (t >> 16);
   endfunction

   task automatic note_mismatch(input string what, input logic [31:0] want,
                                input logic [31:0] got);
      mismatches++;
      if (mismatches <= 10)
         $display("%0t: %s: expected %h, got %h", $time, what, want, got);
   endtask

   always @(posedge clock) begin : watch
      logic [31:0] h;
      logic [31:0] mask;
      logic [31:0] want;
      logic [2:0]  n;
      if (reset) begin
         seed_copy  = '0;
         block_hash = '0;
         key_bytes  = '0;
         key_open   = 1'b0;
         expected_hashes.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            seed_copy = csr_seed;
            if (!key_open)
               block_hash = csr_seed;
         end
         if (req_valid && req_ready) begin
            requests_seen++;
            h = key_open ? block_hash : seed_copy;
            if (!req_last) begin
               block_hash = mix_into(h, req_data_word);
               key_bytes  = key_bytes + 32'd4;
               key_open   = 1'b1;
            end else begin
               n = (req_byte_count > mm3_pkg::BLOCK_BYTES) ? mm3_pkg::BLOCK_BYTES
                                                           : req_byte_count;
               if (n == mm3_pkg::BLOCK_BYTES) begin
                  h = mix_into(h, req_data_word);
               end else if (n != 3'd0) begin
                  mask = (32'h1 << (8 * n)) - 32'h1;
                  h    = h ^ scramble_block(req_data_word & mask);
               end
               key_bytes = key_bytes + 32'(n);
               expected_hashes.push_back(avalanche(h ^ key_bytes));
               block_hash = seed_copy;
               key_bytes  = '0;
               key_open   = 1'b0;
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_hashes.size() == 0) begin
               note_mismatch("hash with nothing pending", 32'h0, rsp_hash_value);
            end else begin
               want = expected_hashes.pop_front();
               hashes_seen++;
               if (want !== rsp_hash_value)
                  note_mismatch("hash mismatch", want, rsp_hash_value);
            end
         end
      end
      fail_count    <= mismatches;
      pending_count <= expected_hashes.size();
      keys_hashed   <= hashes_seen;
      words_seen    <= requests_seen;
   end

endmodule

// ----- test/murmur3_32_stream_hash_core_tb.sv -----
// Testbench top: drives keys and seed writes into the hash core and reports the verdict.
`timescale 1ns / 1ps
module murmur3_32_stream_hash_core_tb;

   logic        clock;
   logic        reset          = 1'b1;
   logic        csr_valid      = 1'b0;
   logic [31:0] csr_seed       = '0;
   logic        req_valid      = 1'b0;
   logic [31:0] req_data_word  = '0;
   logic [2:0]  req_byte_count = '0;
   logic        req_last       = 1'b0;
   logic        rsp_ready      = 1'b0;
   logic        csr_ready;
   logic        req_ready;
   logic        rsp_valid;
   logic [31:0] rsp_hash_value;
   int          fail_count;
   int          pending_count;
   int          keys_hashed;
   int          words_seen;
   bit          quiet = 1'b0;

   murmur3_32_stream_hash_core u_dut (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_seed       (csr_seed),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data_word  (req_data_word),
      .req_byte_count (req_byte_count),
      .req_last       (req_last),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_hash_value (rsp_hash_value)
   );

   murmur3_hash_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_seed       (csr_seed),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data_word  (req_data_word),
      .req_byte_count (req_byte_count),
      .req_last       (req_last),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_hash_value (rsp_hash_value),
      .fail_count     (fail_count),
      .pending_count  (pending_count),
      .keys_hashed    (keys_hashed),
      .words_seen     (words_seen)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   always @(posedge clock) begin
      rsp_ready <= quiet || ($urandom_range(99) >= 8);
   end

   function automatic bit take_gap();
      return !quiet && ($urandom_range(99) < 8);
   endfunction

   task automatic send_req(input logic [31:0] word, input logic [2:0] count, input logic last);
      while (take_gap()) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_data_word  <= word;
      req_byte_count <= count;
      req_last       <= last;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_seed(input logic [31:0] value);
      csr_valid <= 1'b1;
      csr_seed  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_body(input int words);
      for (int i = 0; i < words; i++)
         send_req($urandom, 3'($urandom_range(7)), 1'b0);
   endtask

   initial begin : stimulus
      int  ph;
      int  len;
      int  roll;
      int  phase_words;
      bit  open_key;
      logic [31:0] seed_value;
      open_key = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // single-word keys under the reset seed: every tail length, saturation, masked bytes; then a three-word key
      send_req(32'h0bad_cafe, 3'd0, 1'b1);
      send_req(32'hffff_ffff, 3'd1, 1'b1);
      send_req(32'hffff_ffff, 3'd2, 1'b1);
      send_req(32'hffff_ffff, 3'd3, 1'b1);
      send_req(32'h0000_0000, 3'd3, 1'b1);
      send_req(32'hffff_ffff, 3'd4, 1'b1);
      send_req(32'h8000_0000, 3'd7, 1'b1);
      send_req(32'h1234_5678, 3'd5, 1'b1);
      send_req(32'h8765_4321, 3'd6, 1'b1);
      send_req(32'hffff_ffff, 3'd4, 1'b0);
      send_req(32'h0000_0000, 3'd0, 1'b0);
      send_req(32'ha5a5_a5a5, 3'd3, 1'b1);
      settle();
      write_seed(32'hffff_ffff);
      // change the seed with a key open; it keeps the old one
      send_req(32'hdead_beef, 3'd4, 1'b0);
      send_req(32'h0123_4567, 3'd7, 1'b0);
      settle();
      write_seed(32'h9747_b28c);
      send_req(32'hc0ff_ee00, 3'd2, 1'b1);
      send_req(32'hffff_ffff, 3'd4, 1'b1);

      for (ph = 0; ph < 6; ph++) begin
         settle();
         quiet = (ph == 2);
         seed_value = (ph == 0) ? 32'h0 : (ph == 1) ? 32'hffff_ffff : $urandom;
         write_seed(seed_value);
         if (open_key) begin
            send_req($urandom, 3'($urandom_range(7)), 1'b1);
            open_key = 1'b0;
         end
         phase_words = 0;
         while (phase_words < 108) begin
            roll = $urandom_range(99);
            len  = (roll < 70) ? $urandom_range(4) :
                   (roll < 95) ? $urandom_range(12, 5) : $urandom_range(40, 13);
            send_body(len);
            send_req($urandom, 3'($urandom_range(7)), 1'b1);
            phase_words += len + 1;
         end
         if (ph != 5 && $urandom_range(1) == 1) begin
            send_body($urandom_range(6, 1));
            open_key = 1'b1;
         end
      end
      quiet = 1'b0;
      settle();

      $display("Hashed %0d keys from %0d accepted words under eight seed settings,",
               keys_hashed, words_seen);
      $display("including seed changes with a key open and every tail length.");
      if (fail_count == 0 && pending_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/mm3_pkg.sv
rtl/mm3_front.sv
rtl/mm3_queue.sv
rtl/mm3_back.sv
rtl/murmur3_32_stream_hash_core.sv
test/murmur3_hash_checker.sv
test/murmur3_32_stream_hash_core_tb.sv
